// File: src/kdj_pkg.sv
// ----------------------------------------------------------------------------
// kdj_pkg: shared constants and types of the KDJ oscillator
// Field widths, Q16 constants and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package kdj_pkg;
  localparam int unsigned WindowMaxDef = 64;
  localparam int unsigned PriceBitsDef = 32;
  localparam int unsigned KdBits   = 23;
  localparam int unsigned JBits    = 26;
  localparam int unsigned CfgBits  = 8;
  localparam int unsigned IdxBits  = 2;
  localparam int unsigned LenBits  = 7;
  localparam int unsigned SmBits   = 8;
  localparam logic [KdBits-1:0] Q16Fifty   = 23'd3276800;
  localparam logic [KdBits-1:0] Q16Hundred = 23'd6553600;

  typedef enum logic [IdxBits-1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_K_SMOOTH   = 2'd1,
    REG_D_SMOOTH   = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_e;
endpackage
`default_nettype wire

// File: src/kdj_bar_if.sv
// ----------------------------------------------------------------------------
// kdj_bar_if: price bar channel
// Valid/ready channel carrying one bar.
// ----------------------------------------------------------------------------
`default_nettype none
interface kdj_bar_if #(parameter int unsigned PRICE_BITS = 32);
  logic valid;
  logic ready;
  logic series_start;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;
  modport source (output valid, series_start, high_price, low_price, close_price,
                  input ready);
  modport sink (input valid, series_start, high_price, low_price, close_price,
                output ready);
endinterface
`default_nettype wire

// File: src/kdj_res_if.sv
// ----------------------------------------------------------------------------
// kdj_res_if: oscillator result channel
// Valid/ready channel carrying K, D and J.
// ----------------------------------------------------------------------------
`default_nettype none
interface kdj_res_if;
  logic valid;
  logic ready;
  logic [22:0] k_line;
  logic [22:0] d_line;
  logic signed [25:0] j_line;
  modport source (output valid, k_line, d_line, j_line, input ready);
  modport sink (input valid, k_line, d_line, j_line, output ready);
endinterface
`default_nettype wire

// File: src/kdj_cell.sv
// ----------------------------------------------------------------------------
// kdj_cell: one window slot
// Holds one high/low pair, shifts it onward on a new bar and folds the
// running max/min that flows through the chain one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module kdj_cell #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  shift_i,
  input  wire logic [PRICE_BITS-1:0] hi_i,
  input  wire logic [PRICE_BITS-1:0] lo_i,
  input  wire logic                  use_i,
  input  wire logic [PRICE_BITS-1:0] mx_i,
  input  wire logic [PRICE_BITS-1:0] mn_i,
  output logic      [PRICE_BITS-1:0] hi_o,
  output logic      [PRICE_BITS-1:0] lo_o,
  output logic      [PRICE_BITS-1:0] mx_o,
  output logic      [PRICE_BITS-1:0] mn_o
);
  logic [PRICE_BITS-1:0] hi_q, lo_q, mx_q, mn_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      hi_q <= hi_i;
      lo_q <= lo_i;
    end
    // fold this slot into the running extremes when inside the window
    mx_q <= (use_i && hi_q > mx_i) ? hi_q : mx_i;
    mn_q <= (use_i && lo_q < mn_i) ? lo_q : mn_i;
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;
  assign mx_o = mx_q;
  assign mn_o = mn_q;
endmodule
`default_nettype wire

// File: src/kdj_div.sv
// ----------------------------------------------------------------------------
// kdj_div: restoring divider
// One quotient bit per cycle, numerator below den << NB.
// ----------------------------------------------------------------------------
`default_nettype none
module kdj_div #(
  parameter int unsigned NB = 23,
  parameter int unsigned DB = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NB+DB-1:0] num_i,
  input  wire logic [DB-1:0]    den_i,
  output logic                  done_o,
  output logic      [NB-1:0]    quo_o
);
  localparam int unsigned CB = $clog2(NB + 1);
  logic [DB:0]    rem_q, rem_d;
  logic [NB-1:0]  quo_q;
  logic [NB-1:0]  nlo_q;
  logic [DB-1:0]  den_q;
  logic [CB-1:0]  cnt_q;
  logic           busy_q;
  logic [DB:0]    trial;

  assign trial = {rem_q[DB-1:0], nlo_q[NB-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CB'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[NB+DB-1:NB]};
      nlo_q <= num_i[NB-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      nlo_q <= {nlo_q[NB-2:0], 1'b0};
      quo_q <= {quo_q[NB-2:0], trial >= {1'b0, den_q}};
    end
  end

  assign rem_d = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// File: src/stochastic_kdj_oscillator.sv
// ----------------------------------------------------------------------------
// stochastic_kdj_oscillator: KDJ stochastic oscillator
// Window extremes from a chain of slot cells, RSV and smoothing by one
// shared serial divider.
// ----------------------------------------------------------------------------
// channel  dir  payload
// bar_in   in   series_start, high_price, low_price, close_price
// res_out  out  k_line, d_line, j_line
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// For a full-window bar the extremes settle through the whole cell chain,
// then three divisions of 23 quotient bits (RSV, K, D) run in the shared
// divider. When high equals low or the close is at or beyond an extreme,
// RSV is set to 50, 0 or 100 and its division is skipped. Bars before the
// window fills give no result. Reset empties the series and sets K and D to 50.
// A result waits in its output register; the next bar is taken once the
// previous result is gone.
`default_nettype none
module stochastic_kdj_oscillator
  import kdj_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WindowMaxDef,
  parameter int unsigned PRICE_BITS = PriceBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  kdj_bar_if.sink                 bar_in,
  kdj_res_if.source               res_out,
  input  wire logic               cfg_we_i,
  input  wire logic [IdxBits-1:0] cfg_idx_i,
  input  wire logic [CfgBits-1:0] cfg_data_i
);
  localparam int unsigned FB = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SB = $clog2(WINDOW_MAX + 2);
  localparam int unsigned DB = (PRICE_BITS > 32) ? PRICE_BITS : 32;
  localparam int unsigned NB = KdBits;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_RSV   = 7'b0000100,
    S_KDIV  = 7'b0001000,
    S_DDIV  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [LenBits-1:0] win_q;
  logic [SmBits-1:0]  km_q, dm_q;
  logic [FB-1:0]      filled_q;
  logic [SB-1:0]      scan_q;
  logic [KdBits-1:0]  k_q, d_q;
  logic [PRICE_BITS-1:0] close_q;
  logic [FB-1:0]      len_eff;
  logic [SmBits-1:0]  km, dm;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= LenBits'(9);
      km_q  <= SmBits'(3);
      dm_q  <= SmBits'(3);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WINDOW_LEN: win_q <= cfg_data_i[LenBits-1:0];
        REG_K_SMOOTH:   km_q  <= cfg_data_i[SmBits-1:0];
        REG_D_SMOOTH:   dm_q  <= cfg_data_i[SmBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_q == '0) len_eff = FB'(1);
    else if ({{(32-LenBits){1'b0}}, win_q} > WINDOW_MAX) len_eff = FB'(WINDOW_MAX);
    else len_eff = FB'(win_q);
  end
  assign km = (km_q == '0) ? SmBits'(1) : km_q;
  assign dm = (dm_q == '0) ? SmBits'(1) : dm_q;

  logic accept;
  // hold off new bars while a result still waits
  assign bar_in.ready = (state_q == S_IDLE) && !res_out.valid;
  assign accept = bar_in.valid && bar_in.ready;

  // cell chain: cell 0 holds the newest bar
  logic [PRICE_BITS-1:0] hi_c [WINDOW_MAX+1];
  logic [PRICE_BITS-1:0] lo_c [WINDOW_MAX+1];
  logic [PRICE_BITS-1:0] mx_c [WINDOW_MAX+1];
  logic [PRICE_BITS-1:0] mn_c [WINDOW_MAX+1];
  assign hi_c[0] = bar_in.high_price;
  assign lo_c[0] = bar_in.low_price;
  assign mx_c[0] = '0;
  assign mn_c[0] = '1;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    kdj_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
      .clk_i  (clk_i),
      .shift_i(accept),
      .hi_i   (hi_c[g]),
      .lo_i   (lo_c[g]),
      .use_i  (g < len_eff),
      .mx_i   (mx_c[g]),
      .mn_i   (mn_c[g]),
      .hi_o   (hi_c[g+1]),
      .lo_o   (lo_c[g+1]),
      .mx_o   (mx_c[g+1]),
      .mn_o   (mn_c[g+1])
    );
  end

  logic [PRICE_BITS-1:0] hh, ll;
  assign hh = mx_c[WINDOW_MAX];
  assign ll = mn_c[WINDOW_MAX];

  // shared divider
  logic            dv_start, dv_done;
  logic [NB+DB-1:0] dv_num;
  logic [DB-1:0]   dv_den;
  logic [NB-1:0]   dv_quo;
  logic [NB-1:0]   rsv_q;

  kdj_div #(.NB(NB), .DB(DB)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (dv_den),
    .done_o (dv_done),
    .quo_o  (dv_quo)
  );

  logic flat, below, above, special;
  assign flat  = !(hh > ll);
  assign below = close_q <= ll;
  assign above = close_q >= hh;
  assign special = flat || below || above;

  // RSV comes from the divider unless it is one of the fixed levels
  logic [NB-1:0] rsv_now;
  assign rsv_now = special ? rsv_q : dv_quo;

  // products are below 2^31, within the 31-bit result of the 23x8 multiply
  logic [NB+SmBits-1:0] kprod, dprod;
  assign kprod = k_q * (km - 1'b1) + {{SmBits{1'b0}}, rsv_now};
  assign dprod = d_q * (dm - 1'b1) + {{SmBits{1'b0}}, dv_quo};

  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    unique case (state_q)
      S_SCAN: begin
        dv_num = {{NB{1'b0}}, DB'(close_q - ll)} * Q16Hundred;
        dv_den = DB'(hh - ll);
        dv_start = (scan_q == '0) && !special;
      end
      S_RSV:  begin
        dv_num = (NB+DB)'(kprod);
        dv_den = DB'(km);
        dv_start = dv_done || special;
      end
      S_KDIV: begin
        dv_num = (NB+DB)'(dprod);
        dv_den = DB'(dm);
        dv_start = dv_done;
      end
      default: ;
    endcase
  end

  // RSV numerator is (close-LL)*6553600, quotient field then holds the ratio;
  // smoothing numerators go in as they are, their quotient stays below 2^NB
  logic [KdBits-1:0] res_k, res_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      filled_q <= '0;
      scan_q   <= '0;
      k_q      <= Q16Fifty;
      d_q      <= Q16Fifty;
      close_q  <= '0;
      rsv_q    <= '0;
      res_k    <= '0;
      res_d    <= '0;
      res_out.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_out.valid && res_out.ready) res_out.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) begin
          close_q <= bar_in.close_price;
          scan_q  <= SB'(WINDOW_MAX);
          if (bar_in.series_start) begin
            k_q <= Q16Fifty;
            d_q <= Q16Fifty;
            filled_q <= FB'(1);
          end else if (filled_q < FB'(WINDOW_MAX)) begin
            filled_q <= filled_q + 1'b1;
          end
        end
        S_WAIT: scan_q <= scan_q - 1'b1;
        S_SCAN: begin
          if (flat) rsv_q <= Q16Fifty;
          else if (below) rsv_q <= '0;
          else if (above) rsv_q <= Q16Hundred;
        end
        S_RSV:  if (dv_done && !special) rsv_q <= dv_quo;
        S_KDIV: if (dv_done) k_q <= dv_quo;
        S_DDIV: if (dv_done) begin
          d_q <= dv_quo;
          res_k <= k_q;
          res_d <= dv_quo;
          res_out.valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_OUT;
      // decide whether the window is full
      S_OUT:  state_d = (filled_q < len_eff) ? S_IDLE : S_WAIT;
      S_WAIT: if (scan_q == SB'(1)) state_d = S_SCAN;
      S_SCAN: state_d = S_RSV;
      S_RSV:  if (dv_done || special) state_d = S_KDIV;
      S_KDIV: if (dv_done) state_d = S_DDIV;
      S_DDIV: if (dv_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [JBits-1:0] j3;
  assign j3 = JBits'(res_k) * JBits'(3) - JBits'(res_d) * JBits'(2);
  assign res_out.k_line = res_k;
  assign res_out.d_line = res_d;
  assign res_out.j_line = $signed(j3);
endmodule
`default_nettype wire

// File: src/kdj_checker.sv
// ----------------------------------------------------------------------------
// kdj_checker: port-level checks of the oscillator
// Channel rules, result value ranges and the J relation.
// ----------------------------------------------------------------------------
`default_nettype none
module kdj_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [22:0] k_line,
  input wire logic [22:0] d_line,
  input wire logic [25:0] j_line
);
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> k_line <= 23'd6553600) else $error("K out of range");
  a_d_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> d_line <= 23'd6553600) else $error("D out of range");
  a_j_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> j_line == 26'(3 * k_line) - 26'(2 * d_line)) else $error("J mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(k_line)) else $error("result dropped");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("bar taken back to back");
endmodule

bind stochastic_kdj_oscillator kdj_checker u_kdj_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (bar_in.valid),
  .in_ready (bar_in.ready),
  .out_valid(res_out.valid),
  .out_ready(res_out.ready),
  .k_line   (res_out.k_line),
  .d_line   (res_out.d_line),
  .j_line   (res_out.j_line)
);
`default_nettype wire
